// ----- rtl/core/chic_pkg.sv -----
// Shared constants, command/status types and the arctangent table for the compass calibrator.
package chic_pkg;

   // Iteration count and output angle scale
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 6;

   // Field widths
   localparam int ACTION_W  = 2;
   localparam int MAG_XY_W  = 13;
   localparam int MAG_Z_W   = 15;
   localparam int HEAD_W    = 15;

   // Stream payload widths (fields packed from bit 0, padded to whole bytes)
   localparam int REQ_FIELDS_W = 2 * MAG_XY_W + MAG_Z_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = HEAD_W + 2 * MAG_XY_W + MAG_Z_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_START   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TRACK   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_HEADING = 2'd2;

   // Datapath widths
   localparam int MID_W       = MAG_Z_W + 2;
   localparam int DIFF_W      = MAG_XY_W + 1;
   localparam int GUARD_BITS  = 16;
   localparam int VEC_W       = DIFF_W + GUARD_BITS + 4;
   localparam int ACC_FRAC    = 24;
   localparam int ACC_W       = ACC_FRAC + 11;
   localparam int TABLE_LEN   = 24;
   localparam int TABLE_IDX_W = $clog2(TABLE_LEN);
   localparam int STEP_W      = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int RND_SH      = ACC_FRAC - ANGLE_FRAC_BITS;

   localparam logic [ACC_W-1:0] FULL_TURN  = ACC_W'(360) << ACC_FRAC;
   localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(180) << ACC_FRAC;
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (RND_SH - 1);
   localparam logic [ACC_W-1:0] TURN_UNITS = ACC_W'(360) << ANGLE_FRAC_BITS;

   // Controller to datapath commands
   typedef struct packed {
      logic              accept;
      logic              offset_load;
      logic              prep_load;
      logic              iter_step;
      logic              wrap_load;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } chic_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_heading;
   } chic_sts_type;

   // atan(2^-i) in degrees, scaled by 2^24
   function automatic logic [ACC_W-1:0] atan_q24(input logic [TABLE_IDX_W-1:0] idx);
      logic [ACC_W-1:0] val;
      unique case (idx)
         5'd0:    val = ACC_W'(754974720);
         5'd1:    val = ACC_W'(445687602);
         5'd2:    val = ACC_W'(235489088);
         5'd3:    val = ACC_W'(119537938);
         5'd4:    val = ACC_W'(60000934);
         5'd5:    val = ACC_W'(30029717);
         5'd6:    val = ACC_W'(15018523);
         5'd7:    val = ACC_W'(7509720);
         5'd8:    val = ACC_W'(3754917);
         5'd9:    val = ACC_W'(1877466);
         5'd10:   val = ACC_W'(938734);
         5'd11:   val = ACC_W'(469367);
         5'd12:   val = ACC_W'(234684);
         5'd13:   val = ACC_W'(117342);
         5'd14:   val = ACC_W'(58671);
         5'd15:   val = ACC_W'(29335);
         5'd16:   val = ACC_W'(14668);
         5'd17:   val = ACC_W'(7334);
         5'd18:   val = ACC_W'(3667);
         5'd19:   val = ACC_W'(1833);
         5'd20:   val = ACC_W'(917);
         5'd21:   val = ACC_W'(458);
         5'd22:   val = ACC_W'(229);
         5'd23:   val = ACC_W'(115);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/chic_dp.sv -----
// Datapath: min/max tracking, offsets, iterative CORDIC and the result register.
module chic_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  chic_pkg::chic_cmd_type                cmd,
   output chic_pkg::chic_sts_type                sts,
   input  logic        [chic_pkg::ACTION_W-1:0]  req_action,
   input  logic signed [chic_pkg::MAG_XY_W-1:0]  req_mag_x,
   input  logic signed [chic_pkg::MAG_XY_W-1:0]  req_mag_y,
   input  logic signed [chic_pkg::MAG_Z_W-1:0]   req_mag_z,
   output logic                                  rsp_heading_valid,
   output logic        [chic_pkg::HEAD_W-1:0]    rsp_heading_deg64,
   output logic signed [chic_pkg::MAG_XY_W-1:0]  rsp_offset_x,
   output logic signed [chic_pkg::MAG_XY_W-1:0]  rsp_offset_y,
   output logic signed [chic_pkg::MAG_Z_W-1:0]   rsp_offset_z
);

   function automatic logic signed [chic_pkg::MID_W-1:0] midpoint(
      input logic signed [chic_pkg::MID_W-1:0] lo,
      input logic signed [chic_pkg::MID_W-1:0] hi
   );
      logic signed [chic_pkg::MID_W-1:0] span;
      span = hi - lo;
      return lo + (span >>> 1);
   endfunction

   // extremes
   logic signed [chic_pkg::MAG_XY_W-1:0] min_x_ff, max_x_ff, min_x_in, max_x_in;
   logic signed [chic_pkg::MAG_XY_W-1:0] min_y_ff, max_y_ff, min_y_in, max_y_in;
   logic signed [chic_pkg::MAG_Z_W-1:0]  min_z_ff, max_z_ff, min_z_in, max_z_in;

   // held sample and offsets
   logic                                 heading_ff;
   logic signed [chic_pkg::MAG_XY_W-1:0] x_ff, y_ff;
   logic signed [chic_pkg::MAG_XY_W-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic signed [chic_pkg::MAG_Z_W-1:0]  oz_ff, oz_in;

   // CORDIC state
   logic signed [chic_pkg::DIFF_W-1:0] xc, yc;
   logic signed [chic_pkg::VEC_W-1:0]  vec_x0, vec_y0;
   logic signed [chic_pkg::VEC_W-1:0]  vx_ff, vy_ff, vx_in, vy_in, dx, dy;
   logic signed [chic_pkg::ACC_W-1:0]  ang_ff, ang_in, step_angle;
   logic                               zero_ff, zero_in;

   // rounding
   logic [chic_pkg::ACC_W-1:0]  rnd;
   logic [chic_pkg::HEAD_W-1:0] head_out;

   always_comb begin
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      min_z_in = min_z_ff;
      max_z_in = max_z_ff;
      if (cmd.accept) begin
         if (req_action == chic_pkg::ACT_START) begin
            min_x_in = req_mag_x;
            max_x_in = req_mag_x;
            min_y_in = req_mag_y;
            max_y_in = req_mag_y;
            min_z_in = req_mag_z;
            max_z_in = req_mag_z;
         end else if (req_action == chic_pkg::ACT_TRACK) begin
            if (min_x_ff > req_mag_x) min_x_in = req_mag_x;
            else if (max_x_ff < req_mag_x) max_x_in = req_mag_x;
            if (min_y_ff > req_mag_y) min_y_in = req_mag_y;
            else if (max_y_ff < req_mag_y) max_y_in = req_mag_y;
            if (min_z_ff > req_mag_z) min_z_in = req_mag_z;
            else if (max_z_ff < req_mag_z) max_z_in = req_mag_z;
         end
      end
   end

   assign ox_in = chic_pkg::MAG_XY_W'(midpoint(chic_pkg::MID_W'(min_x_ff),
                                                chic_pkg::MID_W'(max_x_ff)));
   assign oy_in = chic_pkg::MAG_XY_W'(midpoint(chic_pkg::MID_W'(min_y_ff),
                                                chic_pkg::MID_W'(max_y_ff)));
   assign oz_in = chic_pkg::MAG_Z_W'(midpoint(chic_pkg::MID_W'(min_z_ff),
                                               chic_pkg::MID_W'(max_z_ff)));

   // corrected vector, scaled up by the guard bits; CORDIC runs on (y, x)
   assign xc = chic_pkg::DIFF_W'(x_ff) - chic_pkg::DIFF_W'(ox_ff);
   assign yc = chic_pkg::DIFF_W'(y_ff) - chic_pkg::DIFF_W'(oy_ff);
   assign vec_x0 = {{(chic_pkg::VEC_W - chic_pkg::DIFF_W - chic_pkg::GUARD_BITS)
                     {yc[chic_pkg::DIFF_W-1]}}, yc, {chic_pkg::GUARD_BITS{1'b0}}};
   assign vec_y0 = {{(chic_pkg::VEC_W - chic_pkg::DIFF_W - chic_pkg::GUARD_BITS)
                     {xc[chic_pkg::DIFF_W-1]}}, xc, {chic_pkg::GUARD_BITS{1'b0}}};
   assign zero_in = (xc == '0) && (yc == '0);

   assign dx = vy_ff >>> cmd.step;
   assign dy = vx_ff >>> cmd.step;
   assign step_angle = $signed(chic_pkg::atan_q24(chic_pkg::TABLE_IDX_W'(cmd.step)));

   always_comb begin
      vx_in  = vx_ff;
      vy_in  = vy_ff;
      ang_in = ang_ff;
      if (cmd.prep_load) begin
         // left half-plane: rotate by 180 degrees first
         if (yc[chic_pkg::DIFF_W-1]) begin
            vx_in  = -vec_x0;
            vy_in  = -vec_y0;
            ang_in = $signed(chic_pkg::HALF_TURN);
         end else begin
            vx_in  = vec_x0;
            vy_in  = vec_y0;
            ang_in = '0;
         end
      end else if (cmd.iter_step) begin
         if (!vy_ff[chic_pkg::VEC_W-1]) begin
            vx_in  = vx_ff + dx;
            vy_in  = vy_ff - dy;
            ang_in = ang_ff + step_angle;
         end else begin
            vx_in  = vx_ff - dx;
            vy_in  = vy_ff + dy;
            ang_in = ang_ff - step_angle;
         end
      end else if (cmd.wrap_load) begin
         if (ang_ff[chic_pkg::ACC_W-1]) begin
            ang_in = ang_ff + $signed(chic_pkg::FULL_TURN);
         end else if (ang_ff >= $signed(chic_pkg::FULL_TURN)) begin
            ang_in = ang_ff - $signed(chic_pkg::FULL_TURN);
         end
      end
   end

   // round half up to the output scale; a full turn, a zero vector or a non-heading request reads zero
   assign rnd = ($unsigned(ang_ff) + chic_pkg::ROUND_HALF) >> chic_pkg::RND_SH;
   assign head_out = (!heading_ff || zero_ff || rnd >= chic_pkg::TURN_UNITS)
                     ? '0 : chic_pkg::HEAD_W'(rnd);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         min_z_ff <= '0;
         max_z_ff <= '0;
      end else begin
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         min_z_ff <= min_z_in;
         max_z_ff <= max_z_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         heading_ff <= (req_action == chic_pkg::ACT_HEADING);
         x_ff       <= req_mag_x;
         y_ff       <= req_mag_y;
      end
      if (cmd.offset_load) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
      end
      if (cmd.prep_load) zero_ff <= zero_in;
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      ang_ff <= ang_in;
      if (cmd.out_load) begin
         rsp_heading_valid <= heading_ff;
         rsp_heading_deg64 <= head_out;
         rsp_offset_x      <= ox_ff;
         rsp_offset_y      <= oy_ff;
         rsp_offset_z      <= oz_ff;
      end
   end

   assign sts.is_heading = heading_ff;

endmodule

// ----- rtl/core/chic_ctrl.sv -----
// Controller: sequences accept, offset, CORDIC iterations, wrap and result hand-off.
module chic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  chic_pkg::chic_sts_type sts,
   output chic_pkg::chic_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_PREP,
      ST_ITER,
      ST_WRAP,
      ST_FINISH
   } state_type;

   state_type                     state_ff;
   logic [chic_pkg::STEP_W-1:0]   step_ff;
   logic                          rsp_valid_ff;
   logic                          out_free;
   logic                          step_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_last  = (step_ff == chic_pkg::STEP_W'(chic_pkg::CORDIC_STEPS - 1));
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.accept      = (state_ff == ST_IDLE) && req_tvalid;
      cmd.offset_load = (state_ff == ST_OFFSET);
      cmd.prep_load   = (state_ff == ST_PREP);
      cmd.iter_step   = (state_ff == ST_ITER);
      cmd.wrap_load   = (state_ff == ST_WRAP);
      cmd.out_load    = (state_ff == ST_FINISH) && out_free;
      cmd.step        = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result replaces the one taken in the same cycle
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) state_ff <= ST_OFFSET;
            end
            ST_OFFSET: begin
               state_ff <= sts.is_heading ? ST_PREP : ST_FINISH;
            end
            ST_PREP: begin
               step_ff  <= '0;
               state_ff <= ST_ITER;
            end
            ST_ITER: begin
               step_ff <= step_ff + 1'b1;
               if (step_last) state_ff <= ST_WRAP;
            end
            ST_WRAP: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.offset_load, cmd.prep_load, cmd.iter_step,
                cmd.wrap_load, cmd.out_load}))
      else $error("more than one datapath command in a cycle");

   a_accept_to_offset: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_OFFSET))
      else $error("accepted request did not advance to offset");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> !$past(cmd.out_load))
      else $error("result register loaded while occupied");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |->
         (step_ff <= chic_pkg::STEP_W'(chic_pkg::CORDIC_STEPS - 1)))
      else $error("CORDIC step counter out of range");

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish");

endmodule

// ----- rtl/core/compass_hard_iron_calibrate_heading.sv -----
// Top level of the compass hard-iron calibration and heading block.
// Each request carries one signed magnetometer sample and an action. A start-calibration
// request loads the per-axis minimum and maximum with the sample; a calibration request
// lowers a minimum or else raises a maximum; a heading request subtracts the per-axis
// offset (min + floor((max - min) / 2)) from x and y and computes atan2(x, y) with an
// iterative CORDIC, wrapped into 0..360 degrees and rounded to 1/64 degree (0..23039).
// Action code 3 leaves the extremes alone. Every request yields exactly one response
// with the offsets as they stand after that request's update; the heading field reads
// zero unless the valid flag in rsp_tuser is set. The extremes reset to zero, so all
// offsets read zero until calibration begins. The block works on one request at a time:
// a heading request passes through the offset, prep, CORDIC iteration, wrap and finish
// states, the CORDIC loop doing one shift-add step per cycle on a shared adder set;
// calibration and unused requests go from offset straight to finish. The response sits in an
// output register, so the next request is accepted while it waits to be taken; the
// loop only stalls at its final stage if that register is still occupied.
module compass_hard_iron_calibrate_heading (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: mag_x[12:0], mag_y[25:13], mag_z[40:26], zero pad [47:41]
   input  logic [chic_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: action[1:0]
   input  logic [chic_pkg::ACTION_W-1:0]       req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: heading_deg64[14:0], offset_x[27:15], offset_y[40:28], offset_z[55:41]
   output logic [chic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: heading_valid[0]
   output logic                                rsp_tuser
);

   chic_pkg::chic_cmd_type cmd;
   chic_pkg::chic_sts_type sts;

   // unpacked request fields
   logic signed [chic_pkg::MAG_XY_W-1:0] req_mag_x;
   logic signed [chic_pkg::MAG_XY_W-1:0] req_mag_y;
   logic signed [chic_pkg::MAG_Z_W-1:0]  req_mag_z;

   // response fields from the output register
   logic                                 rsp_heading_valid;
   logic        [chic_pkg::HEAD_W-1:0]   rsp_heading_deg64;
   logic signed [chic_pkg::MAG_XY_W-1:0] rsp_offset_x;
   logic signed [chic_pkg::MAG_XY_W-1:0] rsp_offset_y;
   logic signed [chic_pkg::MAG_Z_W-1:0]  rsp_offset_z;

   // split the request payload, lowest field first
   assign req_mag_x = req_tdata[chic_pkg::MAG_XY_W-1:0];
   assign req_mag_y = req_tdata[2*chic_pkg::MAG_XY_W-1:chic_pkg::MAG_XY_W];
   assign req_mag_z = req_tdata[chic_pkg::REQ_FIELDS_W-1:2*chic_pkg::MAG_XY_W];

   // sequencer: owns the handshakes and steps the datapath
   chic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: extremes, offsets, CORDIC and result register
   chic_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_tuser),
      .req_mag_x         (req_mag_x),
      .req_mag_y         (req_mag_y),
      .req_mag_z         (req_mag_z),
      .rsp_heading_valid (rsp_heading_valid),
      .rsp_heading_deg64 (rsp_heading_deg64),
      .rsp_offset_x      (rsp_offset_x),
      .rsp_offset_y      (rsp_offset_y),
      .rsp_offset_z      (rsp_offset_z)
   );

   // pack the response, lowest field first; the payload fills whole bytes exactly
   assign rsp_tdata = {rsp_offset_z, rsp_offset_y, rsp_offset_x, rsp_heading_deg64};
   assign rsp_tuser = rsp_heading_valid;

endmodule

// ----- dv/tb_compass_hard_iron_calibrate_heading.sv -----
// Self-checking testbench for the compass hard-iron calibration and heading block.
module tb_compass_hard_iron_calibrate_heading;

   // action code 3 has no package name; the block must leave its extremes alone
   localparam logic [chic_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int  XY_MIN     = -4096;
   localparam int  XY_MAX     = 4095;
   localparam int  Z_MIN      = -16384;
   localparam int  Z_MAX      = 16383;
   localparam int  Q24        = 24;
   localparam int  ROUND_SH   = Q24 - chic_pkg::ANGLE_FRAC_BITS;
   localparam int  ATAN_LEN   = 24;
   localparam int  LIMIT_CYC  = 600000;
   localparam int  SETTLE_CYC = 40;

   typedef struct packed {
      logic                                 heading_valid;
      logic [chic_pkg::HEAD_W-1:0]          heading_deg64;
      logic signed [chic_pkg::MAG_XY_W-1:0] offset_x;
      logic signed [chic_pkg::MAG_XY_W-1:0] offset_y;
      logic signed [chic_pkg::MAG_Z_W-1:0]  offset_z;
   } heading_result_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [chic_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic [chic_pkg::ACTION_W-1:0]     req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [chic_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              rsp_tuser;

   // predictor state: the tracked extremes of each axis
   int cal_min_x, cal_max_x, cal_min_y, cal_max_y, cal_min_z, cal_max_z;

   // atan(2^-i) in degrees, scaled by 2^24
   longint atan_deg_q24 [0:ATAN_LEN-1] = '{
      754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115
   };

   heading_result_type pending_headings [$];
   heading_result_type got_rsp;
   heading_result_type want_rsp;
   int                 mismatch_count = 0;
   int                 sample_count = 0;
   int                 send_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 rsp_hold_left = 0;

   compass_hard_iron_calibrate_heading u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * LIMIT_CYC);
      $display("FAIL compass_hard_iron_calibrate_heading");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int midpoint(int lo, int hi);
      return lo + ((hi - lo) >>> 1);
   endfunction

   // vectoring CORDIC on (y, x): the angle of the corrected sample, in 1/64 degree
   function automatic logic [chic_pkg::HEAD_W-1:0] cordic_heading(int xc, int yc);
      longint vx, vy, ang, dx, dy, rounded, full;
      full = longint'(360) <<< Q24;
      if (xc == 0 && yc == 0)
         return '0;
      vx  = longint'(yc) <<< 16;
      vy  = longint'(xc) <<< 16;
      ang = 0;
      // fold the left half plane over and start from half a turn
      if (vx < 0) begin
         vx  = -vx;
         vy  = -vy;
         ang = longint'(180) <<< Q24;
      end
      for (int i = 0; i < chic_pkg::CORDIC_STEPS && i < ATAN_LEN; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx  = vx + dx;
            vy  = vy - dy;
            ang = ang + atan_deg_q24[i];
         end else begin
            vx  = vx - dx;
            vy  = vy + dy;
            ang = ang - atan_deg_q24[i];
         end
      end
      if (ang < 0)
         ang = ang + full;
      if (ang >= full)
         ang = ang - full;
      rounded = (ang + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
      // a full turn after rounding reads as north
      if (rounded >= (longint'(360) <<< chic_pkg::ANGLE_FRAC_BITS))
         rounded = 0;
      return rounded[chic_pkg::HEAD_W-1:0];
   endfunction

   function automatic heading_result_type predict_heading(
      logic [chic_pkg::ACTION_W-1:0] action, int x, int y, int z);
      heading_result_type res;
      int ox, oy, oz;
      if (action == chic_pkg::ACT_START) begin
         cal_min_x = x; cal_max_x = x;
         cal_min_y = y; cal_max_y = y;
         cal_min_z = z; cal_max_z = z;
      end else if (action == chic_pkg::ACT_TRACK) begin
         // a sample below the minimum never also raises the maximum
         if (cal_min_x > x) cal_min_x = x; else if (cal_max_x < x) cal_max_x = x;
         if (cal_min_y > y) cal_min_y = y; else if (cal_max_y < y) cal_max_y = y;
         if (cal_min_z > z) cal_min_z = z; else if (cal_max_z < z) cal_max_z = z;
      end
      ox = midpoint(cal_min_x, cal_max_x);
      oy = midpoint(cal_min_y, cal_max_y);
      oz = midpoint(cal_min_z, cal_max_z);
      res.heading_valid = (action == chic_pkg::ACT_HEADING);
      res.heading_deg64 = (action == chic_pkg::ACT_HEADING) ?
                          cordic_heading(x - ox, y - oy) : '0;
      res.offset_x      = chic_pkg::MAG_XY_W'(ox);
      res.offset_y      = chic_pkg::MAG_XY_W'(oy);
      res.offset_z      = chic_pkg::MAG_Z_W'(oz);
      return res;
   endfunction

   // ---------------------------------------------------------------- request side

   // offer one request, hold it until taken, then log its expected response
   task automatic send_sample(logic [chic_pkg::ACTION_W-1:0] action, int x, int y, int z);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(chic_pkg::REQ_DATA_W - chic_pkg::REQ_FIELDS_W){1'b0}},
                     chic_pkg::MAG_Z_W'(z), chic_pkg::MAG_XY_W'(y), chic_pkg::MAG_XY_W'(x)};
      do @(posedge clock); while (!req_tready);
      pending_headings.push_back(predict_heading(action, x, y, z));
      sample_count++;
   endtask

   // drop valid and hold until every response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_headings.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------- response side

   // stall the response channel at random, or for a counted hold-off
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready    <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic report_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.heading_valid = rsp_tuser;
         got_rsp.heading_deg64 = rsp_tdata[14:0];
         got_rsp.offset_x      = rsp_tdata[27:15];
         got_rsp.offset_y      = rsp_tdata[40:28];
         got_rsp.offset_z      = rsp_tdata[55:41];
         if (pending_headings.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want_rsp = pending_headings.pop_front();
            report_field("heading_valid", want_rsp.heading_valid, got_rsp.heading_valid);
            report_field("heading_deg64", want_rsp.heading_deg64, got_rsp.heading_deg64);
            report_field("offset_x", want_rsp.offset_x, got_rsp.offset_x);
            report_field("offset_y", want_rsp.offset_y, got_rsp.offset_y);
            report_field("offset_z", want_rsp.offset_z, got_rsp.offset_z);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // headings straight out of reset use zero offsets
   task automatic test_uncalibrated_heading();
      send_sample(chic_pkg::ACT_HEADING, 0, 0, 0);
      send_sample(chic_pkg::ACT_HEADING, XY_MAX, 0, Z_MAX);
      send_sample(chic_pkg::ACT_HEADING, XY_MIN, 0, Z_MIN);
      send_sample(chic_pkg::ACT_HEADING, 0, XY_MAX, 0);
      send_sample(chic_pkg::ACT_HEADING, 0, XY_MIN, 0);
      send_sample(chic_pkg::ACT_HEADING, XY_MIN, XY_MIN, Z_MIN);
      send_sample(ACT_UNUSED, 1, 2, 3);
      wait_drained();
   endtask

   // widest span on every axis, a heading right on the offset, then a far heading and a reversed pass
   task automatic test_calibration_extremes();
      send_sample(chic_pkg::ACT_START, XY_MIN, XY_MIN, Z_MIN);
      send_sample(chic_pkg::ACT_TRACK, XY_MAX, XY_MAX, Z_MAX);
      send_sample(chic_pkg::ACT_HEADING, -1, -1, 0);
      send_sample(chic_pkg::ACT_HEADING, XY_MAX, XY_MIN, Z_MAX);
      send_sample(ACT_UNUSED, XY_MIN, XY_MAX, Z_MIN);
      send_sample(chic_pkg::ACT_START, XY_MAX, XY_MAX, Z_MAX);
      send_sample(chic_pkg::ACT_TRACK, XY_MIN, XY_MIN, Z_MIN);
      wait_drained();
   endtask

   // zero offsets, then angles near the wrap, the half turn and the axes
   task automatic test_heading_corners();
      send_sample(chic_pkg::ACT_START, 0, 0, 0);
      send_sample(chic_pkg::ACT_HEADING, 0, XY_MAX, 0);
      send_sample(chic_pkg::ACT_HEADING, -1, XY_MAX, 0);
      send_sample(chic_pkg::ACT_HEADING, 1, XY_MAX, 0);
      send_sample(chic_pkg::ACT_HEADING, 0, -1, 0);
      send_sample(chic_pkg::ACT_HEADING, 1, XY_MIN, 0);
      send_sample(chic_pkg::ACT_HEADING, -1, XY_MIN, 0);
      send_sample(chic_pkg::ACT_HEADING, XY_MIN, 1, 0);
      send_sample(chic_pkg::ACT_TRACK, -5, 9, -5);
      send_sample(chic_pkg::ACT_TRACK, 7, -3, 7);
      send_sample(chic_pkg::ACT_HEADING, 1, 3, 0);
      wait_drained();
   endtask

   // hold the response channel off while headings keep coming, then drain
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      rsp_hold_left = 300;
      for (int i = 0; i < 24; i++)
         send_sample(chic_pkg::ACT_HEADING, $urandom_range(0, 8191) + XY_MIN,
                     $urandom_range(0, 8191) + XY_MIN, 0);
      wait_drained();
   endtask

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   function automatic int near(int c, int r, int lo, int hi);
      return clamp(c + int'($urandom_range(0, 2 * r)) - r, lo, hi);
   endfunction

   // one calibration pass around a random hard-iron center, then headings
   task automatic random_session();
      int cx, cy, cz, r, n_track, n_head;
      r  = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(41, XY_MAX);
      cx = $urandom_range(0, 8191) + XY_MIN;
      cy = $urandom_range(0, 8191) + XY_MIN;
      cz = $urandom_range(0, 32767) + Z_MIN;
      n_track = $urandom_range(2, 10);
      n_head  = $urandom_range(2, 8);
      send_sample(chic_pkg::ACT_START, near(cx, r, XY_MIN, XY_MAX),
                  near(cy, r, XY_MIN, XY_MAX), near(cz, 4 * r, Z_MIN, Z_MAX));
      repeat (n_track)
         send_sample(chic_pkg::ACT_TRACK, near(cx, r, XY_MIN, XY_MAX),
                     near(cy, r, XY_MIN, XY_MAX), near(cz, 4 * r, Z_MIN, Z_MAX));
      repeat (n_head) begin
         send_sample(chic_pkg::ACT_HEADING, near(cx, r, XY_MIN, XY_MAX),
                     near(cy, r, XY_MIN, XY_MAX), near(cz, 4 * r, Z_MIN, Z_MAX));
         // advance the calibration now and then between headings
         if ($urandom_range(3) == 0)
            send_sample(chic_pkg::ACT_TRACK, near(cx, r, XY_MIN, XY_MAX),
                        near(cy, r, XY_MIN, XY_MAX), near(cz, 4 * r, Z_MIN, Z_MAX));
      end
   endtask

   function automatic logic [chic_pkg::ACTION_W-1:0] ACT_ACTION_ANY();
      return chic_pkg::ACTION_W'($urandom_range(0, 3));
   endfunction

   // mostly whole sessions, the rest full-range samples with any action code
   task automatic test_random_sessions(int n_samples, int send_pct, int rsp_pct);
      int first;
      first         = sample_count;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      while (sample_count - first < n_samples) begin
         if ($urandom_range(99) < 80)
            random_session();
         else
            send_sample(ACT_ACTION_ANY(), $urandom_range(0, 8191) + XY_MIN,
                        $urandom_range(0, 8191) + XY_MIN, $urandom_range(0, 32767) + Z_MIN);
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= chic_pkg::ACT_START;
      rsp_tready <= 1'b0;
      cal_min_x = 0; cal_max_x = 0;
      cal_min_y = 0; cal_max_y = 0;
      cal_min_z = 0; cal_max_z = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 12;
      rsp_idle_pct  = 77;
      test_uncalibrated_heading();
      test_calibration_extremes();
      test_heading_corners();
      test_output_backpressure();
      test_random_sessions(500, 12, 77);
      test_random_sessions(500, 77, 12);
      test_random_sessions(500, 0, 0);

      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS compass_hard_iron_calibrate_heading");
      else
         $display("FAIL compass_hard_iron_calibrate_heading");
      $finish;
   end

endmodule
